>>> rtl/core/ffab_pkg.sv
// shared types and constants for the first-fit aligned block allocator
`timescale 1ns / 1ps

package ffab_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam logic [31:0] CHUNK_RESET = 32'd65536;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_NO_FIT     = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] req_size;
    logic [16:0] align_bytes;
    logic [31:0] free_offset;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] block_offset;
  } rsp_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_MODW,
    S_FIT,
    S_DECIDE,
    S_WMAIN,
    S_NEXT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    init_wr;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    mod_start;
    logic    eval_fit;
    logic    wr_split;
    logic    wr_main;
    logic    wr_free;
    logic    set_status;
    status_t code;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic too_large;
    logic entry_free;
    logic offset_match;
    logic mod_done;
    logic fit;
    logic need_split;
    logic table_full;
    logic last_idx;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/ffab_mod.sv
// iterative remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module ffab_mod
  import ffab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [16:0] rem
);

  logic [31:0] dvd;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;

  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= 17'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[16:0];
      end
    end
  end

endmodule

>>> rtl/core/ffab_dp.sv
// allocator datapath: block table, scan index, fit arithmetic, result register
`timescale 1ns / 1ps

module ffab_dp
  import ffab_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  output rsp_t        rsp,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  entry_t            mem [MAX_BLOCKS];
  entry_t            rd_q;
  req_t              req_q;
  logic [31:0]       chunk;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [16:0]       align_eff;
  logic              mod_done;
  logic [16:0]       mod_rem;
  logic [16:0]       pad;
  logic [31:0]       pad32;
  logic              fit;
  logic [31:0]       avail;
  logic [31:0]       start;
  status_t           res_status;
  logic [31:0]       res_where;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;

  assign align_eff = (req_q.align_bytes == 17'd0) ? 17'd1 : req_q.align_bytes;

  ffab_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (rd_q.offset),
    .divisor  (align_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign pad   = (mod_rem == 17'd0) ? 17'd0 : (align_eff - mod_rem);
  assign pad32 = {15'd0, pad};

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.eval_fit) begin
      fit   <= (pad32 <= rd_q.size) && ((rd_q.size - pad32) >= req_q.req_size);
      avail <= rd_q.size - pad32;
      start <= rd_q.offset + pad32;
    end
  end

  // table write port, config has priority; the user must write config only while idle, the block does not enforce it
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd_q;
    priority if (cfg_wr_en || cmd.init_wr) begin
      we           = 1'b1;
      waddr        = '0;
      wdata.offset = 32'd0;
      wdata.size   = cfg_wr_en ? cfg_wr_data : chunk;
      wdata.free   = 1'b1;
    end else if (cmd.wr_split) begin
      we           = 1'b1;
      waddr        = count[IDX_W-1:0];
      wdata.offset = start + req_q.req_size;
      wdata.size   = avail - req_q.req_size;
      wdata.free   = 1'b1;
    end else if (cmd.wr_main) begin
      we           = 1'b1;
      wdata.offset = start;
      wdata.size   = req_q.req_size;
      wdata.free   = 1'b0;
    end else if (cmd.wr_free) begin
      we         = 1'b1;
      wdata.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= CHUNK_RESET;
      count <= CNT_W'(1);
      idx   <= '0;
    end else begin
      if (cfg_wr_en) begin
        chunk <= cfg_wr_data;
      end
      if (cfg_wr_en || cmd.init_wr) begin
        count <= CNT_W'(1);
      end else if (cmd.wr_split) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      res_where <= 32'd0;
    end else if (cmd.wr_main) begin
      res_where <= start;
    end
    if (cmd.set_status) begin
      res_status <= cmd.code;
    end
    if (cmd.res_load) begin
      rsp.status       <= res_status;
      rsp.block_offset <= res_where;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign stat.is_alloc     = (req_q.cmd == CMD_ALLOC);
  assign stat.too_large    = (chunk < req_q.req_size);
  assign stat.entry_free   = rd_q.free;
  assign stat.offset_match = (rd_q.offset == req_q.free_offset);
  assign stat.mod_done     = mod_done;
  assign stat.fit          = fit;
  assign stat.need_split   = (avail != req_q.req_size);
  assign stat.table_full   = (count >= CNT_W'(MAX_BLOCKS));
  assign stat.last_idx     = ((CNT_W'(idx) + CNT_W'(1)) >= count);
  assign stat.out_free     = !rsp_valid || !rsp_stall;

endmodule

>>> rtl/core/ffab_ctrl.sv
// allocator controller: scan sequencing and result hand-off
`timescale 1ns / 1ps

module ffab_ctrl
  import ffab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) state_next = S_START;
      end
      S_START: begin
        if (stat.is_alloc && stat.too_large) state_next = S_RESULT;
        else state_next = S_READ;
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (stat.is_alloc) begin
          state_next = stat.entry_free ? S_MODW : S_NEXT;
        end else if (!stat.entry_free && stat.offset_match) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_MODW: begin
        if (stat.mod_done) state_next = S_FIT;
      end
      S_FIT: state_next = S_DECIDE;
      S_DECIDE: begin
        priority if (!stat.fit) state_next = S_NEXT;
        else if (stat.need_split && stat.table_full) state_next = S_RESULT;
        else state_next = S_WMAIN;
      end
      S_WMAIN: state_next = S_RESULT;
      S_NEXT: state_next = stat.last_idx ? S_RESULT : S_READ;
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.code  = ST_OK;
    req_stall = (state != S_IDLE);
    unique case (state)
      S_INIT: cmd.init_wr = 1'b1;
      S_IDLE: cmd.load_req = req_valid;
      S_START: begin
        if (stat.is_alloc && stat.too_large) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_TOO_LARGE;
        end else begin
          cmd.idx_clr = 1'b1;
        end
      end
      S_READ: cmd.rd_en = 1'b1;
      S_EVAL: begin
        if (stat.is_alloc) begin
          cmd.mod_start = stat.entry_free;
        end else if (!stat.entry_free && stat.offset_match) begin
          cmd.wr_free    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.code       = ST_OK;
        end
      end
      S_MODW: ;
      S_FIT: cmd.eval_fit = 1'b1;
      S_DECIDE: begin
        if (stat.fit && stat.need_split) begin
          if (stat.table_full) begin
            cmd.set_status = 1'b1;
            cmd.code       = ST_TABLE_FULL;
          end else begin
            cmd.wr_split = 1'b1;
          end
        end
      end
      S_WMAIN: begin
        cmd.wr_main    = 1'b1;
        cmd.set_status = 1'b1;
        cmd.code       = ST_OK;
      end
      S_NEXT: begin
        if (stat.last_idx) begin
          cmd.set_status = 1'b1;
          cmd.code       = stat.is_alloc ? ST_NO_FIT : ST_NOT_FOUND;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RESULT: cmd.res_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/first_fit_aligned_block_allocator.sv
// top level of the first-fit aligned block allocator
//
//   channel  signals                      direction  payload
//   request  req_valid, req_stall, req    in         cmd, req_size, align_bytes, free_offset
//   result   rsp_valid, rsp_stall, rsp    out        status, block_offset
//   config   cfg_wr_en, cfg_wr_data       in         chunk_bytes
//
// one transaction at a time; a request is taken only in idle, a result waits in its register
// an allocate reads and evaluates each entry in turn and runs the 32-step remainder unit
// on each free one; a free only reads and compares each scanned entry
// reset and a chunk_bytes write restore the table to one free block; after reset the init
// state rewrites entry zero before the first request is taken
// a stalled result holds the controller in its result state
`timescale 1ns / 1ps

module first_fit_aligned_block_allocator
  import ffab_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffab_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a transaction is in flight");

  a_offset_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.block_offset == 32'd0))
    else $error("rejected transaction carries a nonzero offset");

  a_init_after_reset: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request accepted before table init");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !cmd.res_load)
    else $error("result overwritten while stalled");
`endif

endmodule

>>> test/ffab_checker.sv
// checker for the block allocator: mirrors the block table and compares every result
`timescale 1ns / 1ps

module ffab_checker
  import ffab_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          fail_count,
  output int          outstanding
);

  logic [31:0] chunk;
  logic [31:0] blk_off [MAX_BLOCKS];
  logic [31:0] blk_size[MAX_BLOCKS];
  logic        blk_free[MAX_BLOCKS];
  int          blk_count;
  rsp_t        pending_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic void clear_table();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_off[i]  = '0;
      blk_size[i] = '0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = chunk;
    blk_free[0] = 1'b1;
    blk_count   = 1;
  endfunction

  function automatic rsp_t predict_alloc(logic [31:0] want, logic [16:0] align_in);
    rsp_t        r;
    logic [31:0] align;
    logic [31:0] rem;
    logic [31:0] pad;
    logic [31:0] avail;
    logic [31:0] start;
    logic [63:0] sum;
    r.status       = ST_NO_FIT;
    r.block_offset = '0;
    align = (align_in == '0) ? 32'd1 : {15'd0, align_in};
    if (chunk < want) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_free[i]) continue;
      rem = blk_off[i] % align;
      pad = (rem != 0) ? align - rem : 32'd0;
      if (pad > blk_size[i]) continue;
      avail = blk_size[i] - pad;
      if (avail < want) continue;
      sum   = {32'd0, blk_off[i]} + {32'd0, pad};
      start = sum[31:0];
      if (avail != want) begin
        if (blk_count >= MAX_BLOCKS) begin
          r.status = ST_TABLE_FULL;
          return r;
        end
        sum = {32'd0, start} + {32'd0, want};
        blk_off[blk_count]  = sum[31:0];
        blk_size[blk_count] = avail - want;
        blk_free[blk_count] = 1'b1;
        blk_count++;
      end
      blk_off[i]     = start;
      blk_size[i]    = want;
      blk_free[i]    = 1'b0;
      r.status       = ST_OK;
      r.block_offset = start;
      return r;
    end
    return r;
  endfunction

  function automatic rsp_t predict_release(logic [31:0] where);
    rsp_t r;
    r.status       = ST_NOT_FOUND;
    r.block_offset = '0;
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_free[i] && blk_off[i] == where) begin
        blk_free[i] = 1'b1;
        r.status    = ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want_rsp;
    if (rst) begin
      chunk = CHUNK_RESET;
      clear_table();
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        chunk = cfg_wr_data;
        clear_table();
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result status %0d offset %h", $time, rsp.status,
                   rsp.block_offset);
        end else begin
          want_rsp = pending_results.pop_front();
          if (rsp.status !== want_rsp.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, want_rsp.status,
                     rsp.status);
          end
          if (rsp.block_offset !== want_rsp.block_offset) begin
            fail_count++;
            $display("%0t: block_offset expected %h actual %h", $time,
                     want_rsp.block_offset, rsp.block_offset);
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (req.cmd == CMD_ALLOC) want_rsp = predict_alloc(req.req_size, req.align_bytes);
        else want_rsp = predict_release(req.free_offset);
        pending_results = {pending_results, want_rsp};
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> test/first_fit_aligned_block_allocator_test.sv
// testbench top: drives requests, chunk writes and result stalls, gives the verdict
`timescale 1ns / 1ps

module first_fit_aligned_block_allocator_test
  import ffab_pkg::*;
();

  localparam int  RANDOM_ITEMS = 1400;
  localparam int  PHASE_ITEMS  = 140;
  localparam longint CYCLE_LIMIT = 15_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  int          fail_count;
  int          outstanding;

  logic [31:0] chunk_now = CHUNK_RESET;
  logic [31:0] live_offsets[$];
  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;
  int          stall_left = 0;
  longint      cycles = 0;

  always #5 clk = ~clk;

  first_fit_aligned_block_allocator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  ffab_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // result side: random stall per transaction, remember granted offsets for later frees
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp.status == ST_OK && rsp.block_offset != 0) begin
        live_offsets = {live_offsets, rsp.block_offset};
      end
      stall_left = quiet_rx ? 0 : $urandom_range(0, 10);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    rsp_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(input req_t item);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (!req_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (outstanding == 0) break;
    end
    @(posedge clk);
  endtask

  task automatic write_chunk(input logic [31:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chunk_now = value;
    live_offsets.delete();
  endtask

  function automatic req_t alloc_item(logic [31:0] want, logic [16:0] align);
    req_t r;
    r.cmd         = CMD_ALLOC;
    r.req_size    = want;
    r.align_bytes = align;
    r.free_offset = $urandom;
    return r;
  endfunction

  function automatic req_t free_item(logic [31:0] where);
    req_t r;
    r.cmd         = CMD_FREE;
    r.req_size    = $urandom;
    r.align_bytes = 17'($urandom);
    r.free_offset = where;
    return r;
  endfunction

  function automatic req_t random_item();
    logic [31:0] want;
    logic [16:0] align;
    int          pick;
    int          k;
    if ($urandom_range(0, 99) < 35) begin
      pick = $urandom_range(0, 9);
      if (live_offsets.size() > 0 && pick < 7) begin
        k = $urandom_range(0, live_offsets.size() - 1);
        want = live_offsets[k];
        live_offsets.delete(k);
        return free_item(want);
      end
      if (pick == 7) return free_item(32'd0);
      return free_item($urandom);
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) want = $urandom;
    else if (pick == 1) want = chunk_now;
    else if (pick == 2) want = chunk_now + 1;
    else if (pick == 3) want = 32'd0;
    else want = $urandom_range(0, (chunk_now >> 5) + 1);
    pick = $urandom_range(0, 9);
    if (pick < 7) align = 17'd1 << $urandom_range(0, 16);
    else if (pick == 7) align = '0;
    else align = 17'($urandom_range(0, 131071));
    return alloc_item(want, align);
  endfunction

  initial begin
    logic [31:0] chunk_list[6];
    int          sent;
    chunk_list = '{32'd4096, 32'hFFFF_FFFF, 32'd1, 32'd100000, 32'd0, 32'd65536};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero alignment, padding past a block, missing frees
    send(alloc_item(32'd0, 17'd0));
    send(alloc_item(32'd3, 17'd1));
    send(alloc_item(32'd16, 17'd65536));
    send(alloc_item(32'd5, 17'h1FFFF));
    send(alloc_item(32'hFFFF_FFFF, 17'd1));
    send(alloc_item(32'd65536, 17'd1));
    send(free_item(32'd3));
    send(free_item(32'd3));
    send(free_item(32'hFFFF_FFFF));
    send(free_item(32'd0));
    send(alloc_item(32'd1, 17'd8));
    send(alloc_item(32'd0, 17'd4));
    write_chunk(32'd0);
    send(alloc_item(32'd0, 17'd1));
    send(alloc_item(32'd1, 17'd1));
    write_chunk(32'd10);
    send(alloc_item(32'd3, 17'd1));
    send(alloc_item(32'd2, 17'd8));
    send(alloc_item(32'd7, 17'd1));
    send(alloc_item(32'd10, 17'd1));
    write_chunk(32'hFFFF_FFFF);
    send(alloc_item(32'hFFFF_FFF0, 17'd65536));
    send(alloc_item(32'hFFFF_FFFF, 17'd1));
    send(free_item(32'd0));
    send(alloc_item(32'hFFFF_FFFF, 17'd1));

    sent = 0;
    for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
      if (ph % 3 == 0) write_chunk($urandom);
      else write_chunk(chunk_list[ph % 6]);
      quiet_tx = (ph % 4 == 1);
      quiet_rx = (ph % 4 == 2);
      for (int n = 0; n < PHASE_ITEMS && sent < RANDOM_ITEMS; n++) begin
        send(random_item());
        sent++;
        if (n == PHASE_ITEMS / 2 && ph == 1) drain();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
